>>> sv/position_pid_with_deadband_assert.svh
// Assertion macros for the position PID controller with deadband.
`ifndef POSITION_PID_WITH_DEADBAND_ASSERT_SVH
`define POSITION_PID_WITH_DEADBAND_ASSERT_SVH

// Checks in the same cycle that the consequent holds whenever the antecedent holds.
`define PPID_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks in the next cycle that the consequent holds after the antecedent held.
`define PPID_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/ppid_pkg.sv
// Shared widths, register indexes and divider constants for the position PID block.
`timescale 1ns / 1ps
package ppid_pkg;

    localparam int PP_SUM_WIDTH = 40;

    localparam int SP_W   = 14;
    localparam int MEAS_W = 32;
    localparam int GAIN_W = 14;
    localparam int BAND_W = 10;
    localparam int LIM_W  = 10;
    localparam int DRV_W  = 11;
    localparam int DUTY_W = 10;
    localparam int ERR_W  = 33;
    localparam int DIFF_W = 34;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_BAND   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_LIMIT = 3'd4;

    localparam logic [GAIN_W-1:0] GAIN_RST  = 14'd0;
    localparam logic [BAND_W-1:0] BAND_RST  = 10'd30;
    localparam logic [LIM_W-1:0]  LIMIT_RST = 10'd49;

    // Floor division by 1000 of a biased 21-bit value through a reciprocal.
    localparam int DIV_X_W    = 21;
    localparam int DIV_Q_W    = 11;
    localparam int DIV_R_W    = 22;
    localparam int DIV_P_W    = DIV_X_W + DIV_R_W;
    localparam int DIV_SHIFT  = 31;
    localparam int THR_W      = 20;
    localparam logic [DIV_R_W-1:0] DIV_RECIP  = 22'd2147483;
    localparam logic [DIV_X_W-1:0] DIVISOR    = 21'd1000;
    localparam logic [DIV_X_W-1:0] DIV_OFFSET = 21'd1024000;
    localparam logic [DIV_Q_W-1:0] DIV_BIAS   = 11'd1024;

endpackage

>>> sv/ppid_cmd_if.sv
// Input channel carrying one control tick: set point and measured position.
`timescale 1ns / 1ps
interface ppid_cmd_if import ppid_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [SP_W-1:0]          set_point;
    logic signed [MEAS_W-1:0] measured_position;

    modport source (output valid, set_point, measured_position, input ready);
    modport sink (input valid, set_point, measured_position, output ready);
endinterface

>>> sv/ppid_drv_if.sv
// Output channel carrying one drive result per control tick.
`timescale 1ns / 1ps
interface ppid_drv_if import ppid_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [DRV_W-1:0] drive_command;
    logic [DUTY_W-1:0]       duty;
    logic                    turn_forward;
    logic                    turn_reverse;
    logic                    held_in_band;

    modport source (output valid, drive_command, duty, turn_forward, turn_reverse,
                    held_in_band, input ready);
    modport sink (input valid, drive_command, duty, turn_forward, turn_reverse,
                  held_in_band, output ready);
endinterface

>>> sv/position_pid_with_deadband.sv
// Position PID controller with deadband, eight register stages, one tick per cycle unless stalled.
// A result is registered through every stage in order and may wait while the output stalls.
// Throughput: one transaction per cycle unless stalled, bound by the stage-two state update.
// Reset (i_rst_n, synchronous, active low) clears stage valids, integral and last error,
// and returns gains to 0, deadband to 30 and drive limit to 49.
`timescale 1ns / 1ps
`include "position_pid_with_deadband_assert.svh"
module position_pid_with_deadband import ppid_pkg::*; #(
    parameter int SUM_WIDTH = PP_SUM_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    ppid_cmd_if.sink              i_cmd,
    ppid_drv_if.source            o_drv,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Widths of the product and sum path. The integral product is split at bit 32
    // so that no multiplier exceeds 15 by 34 bits.
    localparam int HI_W = SUM_WIDTH - 32;
    localparam int PE_W = GAIN_W + 1 + ERR_W;
    localparam int PD_W = GAIN_W + 1 + DIFF_W;
    localparam int PL_W = GAIN_W + 32;
    localparam int PH_W = GAIN_W + 1 + HI_W;
    localparam int P1_W = PD_W + 1;
    localparam int P2_W = SUM_WIDTH + 15;
    localparam int TW   = SUM_WIDTH + 16;

    // Configuration registers.
    logic [GAIN_W-1:0] r_gain_p;
    logic [GAIN_W-1:0] r_gain_i;
    logic [GAIN_W-1:0] r_gain_d;
    logic [BAND_W-1:0] r_dead_band;
    logic [LIM_W-1:0]  r_drive_limit;

    // Controller state.
    logic signed [SUM_WIDTH-1:0] r_error_sum;
    logic signed [ERR_W-1:0]     r_last_error;

    // Stage advance: a stage loads when it is empty or its contents move on.
    logic [8:1] adv;

    // Stage registers.
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7, r_v8;
    logic [SP_W-1:0]          r_sp1;
    logic signed [MEAS_W-1:0] r_meas1;

    logic                        r_band2;
    logic signed [ERR_W-1:0]     r_e2;
    logic signed [DIFF_W-1:0]    r_d2;
    logic signed [SUM_WIDTH-1:0] r_s2;

    logic                   r_band3;
    logic signed [PE_W-1:0] r_pe3;
    logic signed [PD_W-1:0] r_pd3;
    logic [PL_W-1:0]        r_plo3;
    logic signed [PH_W-1:0] r_phi3;

    logic                   r_band4;
    logic signed [P1_W-1:0] r_p14;
    logic signed [P2_W-1:0] r_p24;

    logic                 r_band5;
    logic signed [TW-1:0] r_t5;

    logic               r_band6, r_hi6, r_lo6;
    logic [DIV_X_W-1:0] r_x6;

    logic r_band7, r_hi7, r_lo7;

    logic                    r_band8, r_fwd8, r_rev8;
    logic signed [DRV_W-1:0] r_drive8;
    logic [DUTY_W-1:0]       r_duty8;

    // Combinational values between stages.
    logic signed [ERR_W-1:0]     n_e;
    logic signed [ERR_W-1:0]     db_s;
    logic                        n_in_band;
    logic signed [SUM_WIDTH:0]   sum_ext;
    logic signed [SUM_WIDTH-1:0] n_sum;
    logic signed [DIFF_W-1:0]    n_d;
    logic                        commit;

    logic signed [PE_W-1:0] n_pe;
    logic signed [PD_W-1:0] n_pd;
    logic [PL_W-1:0]        n_plo;
    logic signed [PH_W-1:0] n_phi;

    logic signed [P1_W-1:0] n_p1;
    logic signed [P2_W-1:0] n_p2;
    logic signed [TW-1:0]   n_t;

    logic [THR_W-1:0]     thr;
    logic signed [TW-1:0] thr_s;
    logic                 n_hi, n_lo;
    logic [DIV_X_W-1:0]   n_x;

    logic [DIV_Q_W-1:0]      quot;
    logic signed [DRV_W-1:0] drv_raw;
    logic signed [DRV_W-1:0] lim_s;
    logic signed [DRV_W-1:0] n_drive;
    logic [DRV_W-1:0]        mag;

    // The advance chain lets bubbles collapse, so new transactions enter while a
    // finished result waits at the output.
    always_comb begin
        adv[8] = !r_v8 || o_drv.ready;
        adv[7] = !r_v7 || adv[8];
        adv[6] = !r_v6 || adv[7];
        adv[5] = !r_v5 || adv[6];
        adv[4] = !r_v4 || adv[5];
        adv[3] = !r_v3 || adv[4];
        adv[2] = !r_v2 || adv[3];
        adv[1] = !r_v1 || adv[2];
    end

    assign i_cmd.ready = adv[1];

    // Configuration writes. Indexes past the register list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p      <= GAIN_RST;
            r_gain_i      <= GAIN_RST;
            r_gain_d      <= GAIN_RST;
            r_dead_band   <= BAND_RST;
            r_drive_limit <= LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_GAIN_P:      r_gain_p      <= i_cfg_data;
                CFG_GAIN_I:      r_gain_i      <= i_cfg_data;
                CFG_GAIN_D:      r_gain_d      <= i_cfg_data;
                CFG_DEAD_BAND:   r_dead_band   <= i_cfg_data[BAND_W-1:0];
                CFG_DRIVE_LIMIT: r_drive_limit <= i_cfg_data[LIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Valid bits for every stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
            r_v8 <= 1'b0;
        end else begin
            if (adv[1]) r_v1 <= i_cmd.valid;
            if (adv[2]) r_v2 <= r_v1;
            if (adv[3]) r_v3 <= r_v2;
            if (adv[4]) r_v4 <= r_v3;
            if (adv[5]) r_v5 <= r_v4;
            if (adv[6]) r_v6 <= r_v5;
            if (adv[7]) r_v7 <= r_v6;
            if (adv[8]) r_v8 <= r_v7;
        end
    end

    // Stage one: capture the transaction.
    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            r_sp1   <= i_cmd.set_point;
            r_meas1 <= i_cmd.measured_position;
        end
    end

    // Stage two: error, deadband test and the state update. The integral adds the
    // error in one extra bit and saturates when that bit disagrees with the sign.
    always_comb begin
        n_e       = $signed(ERR_W'(r_sp1)) - ERR_W'(r_meas1);
        db_s      = $signed(ERR_W'(r_dead_band));
        n_in_band = (n_e > -db_s) && (n_e < db_s);
        sum_ext   = (SUM_WIDTH + 1)'(r_error_sum) + (SUM_WIDTH + 1)'(n_e);
        if (sum_ext[SUM_WIDTH] != sum_ext[SUM_WIDTH-1]) begin
            n_sum = sum_ext[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}}
                                       : {1'b0, {(SUM_WIDTH-1){1'b1}}};
        end else begin
            n_sum = sum_ext[SUM_WIDTH-1:0];
        end
        n_d    = DIFF_W'(n_e) - DIFF_W'(r_last_error);
        commit = r_v1 && adv[2];
    end

    // A tick inside the deadband leaves both the integral and the last error alone.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_error_sum  <= '0;
            r_last_error <= '0;
        end else if (commit && !n_in_band) begin
            r_error_sum  <= n_sum;
            r_last_error <= n_e;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[2]) begin
            r_band2 <= n_in_band;
            r_e2    <= n_e;
            r_d2    <= n_d;
            r_s2    <= n_sum;
        end
    end

    // Stage three: the four gain products. The integral is multiplied as an
    // unsigned low word and a signed high part.
    always_comb begin
        n_pe  = $signed({1'b0, r_gain_p}) * r_e2;
        n_pd  = $signed({1'b0, r_gain_d}) * r_d2;
        n_plo = PL_W'(r_gain_i) * PL_W'(r_s2[31:0]);
        n_phi = $signed({1'b0, r_gain_i}) * $signed(r_s2[SUM_WIDTH-1:32]);
    end

    always_ff @(posedge i_clk) begin
        if (adv[3]) begin
            r_band3 <= r_band2;
            r_pe3   <= n_pe;
            r_pd3   <= n_pd;
            r_plo3  <= n_plo;
            r_phi3  <= n_phi;
        end
    end

    // Stage four: proportional plus derivative, and the two integral halves joined.
    always_comb begin
        n_p1 = P1_W'(r_pe3) + P1_W'(r_pd3);
        n_p2 = $signed({r_phi3, 32'b0}) + $signed(P2_W'(r_plo3));
    end

    always_ff @(posedge i_clk) begin
        if (adv[4]) begin
            r_band4 <= r_band3;
            r_p14   <= n_p1;
            r_p24   <= n_p2;
        end
    end

    // Stage five: the full weighted sum, still scaled by 1000.
    always_comb begin
        n_t = TW'(r_p14) + TW'(r_p24);
    end

    always_ff @(posedge i_clk) begin
        if (adv[5]) begin
            r_band5 <= r_band4;
            r_t5    <= n_t;
        end
    end

    // Stage six: clamp decisions on the scaled sum. The quotient reaches the limit
    // when the sum is at least limit*1000, and the negative limit when the sum is
    // below (1 - limit)*1000. Between the two the sum is small, so its low bits
    // plus a bias give a positive value for the divider.
    always_comb begin
        thr   = THR_W'(r_drive_limit) * THR_W'(DIVISOR);
        thr_s = $signed(TW'(thr));
        n_hi  = r_t5 >= thr_s;
        n_lo  = (r_t5 + thr_s) < $signed(TW'(DIVISOR));
        n_x   = r_t5[DIV_X_W-1:0] + DIV_OFFSET;
    end

    always_ff @(posedge i_clk) begin
        if (adv[6]) begin
            r_band6 <= r_band5;
            r_hi6   <= n_hi;
            r_lo6   <= n_lo;
            r_x6    <= n_x;
        end
    end

    // Stage seven: the reciprocal product sits inside the divider.
    ppid_div1000 u_div (
        .i_clk  (i_clk),
        .i_load (adv[7]),
        .i_x    (r_x6),
        .o_quot (quot)
    );

    always_ff @(posedge i_clk) begin
        if (adv[7]) begin
            r_band7 <= r_band6;
            r_hi7   <= r_hi6;
            r_lo7   <= r_lo6;
        end
    end

    // Stage eight: remove the bias, zero deadband results, apply the clamp and form duty and direction.
    always_comb begin
        drv_raw = $signed(quot - DIV_BIAS);
        lim_s   = $signed(DRV_W'(r_drive_limit));
        priority if (r_band7) begin
            n_drive = '0;
        end else if (r_hi7) begin
            n_drive = lim_s;
        end else if (r_lo7) begin
            n_drive = -lim_s;
        end else begin
            n_drive = drv_raw;
        end
        mag = n_drive[DRV_W-1] ? DRV_W'(-n_drive) : DRV_W'(n_drive);
    end

    always_ff @(posedge i_clk) begin
        if (adv[8]) begin
            r_band8  <= r_band7;
            r_drive8 <= n_drive;
            r_duty8  <= mag[DUTY_W-1:0];
            r_fwd8   <= !n_drive[DRV_W-1] && (n_drive != '0);
            r_rev8   <= n_drive[DRV_W-1];
        end
    end

    assign o_drv.valid         = r_v8;
    assign o_drv.drive_command = r_drive8;
    assign o_drv.duty          = r_duty8;
    assign o_drv.turn_forward  = r_fwd8;
    assign o_drv.turn_reverse  = r_rev8;
    assign o_drv.held_in_band  = r_band8;

    // A deadband result carries no drive and no direction.
    `PPID_ASSERT_IMPLIES(a_band_zero, i_clk, i_rst_n, r_v8 && r_band8, (r_drive8 == '0) && !r_fwd8 && !r_rev8, "deadband result carries drive")
    // The two direction outputs never assert together.
    `PPID_ASSERT_IMPLIES(a_dir_excl, i_clk, i_rst_n, r_v8, !(r_fwd8 && r_rev8), "both directions asserted")
    // A deadband tick leaves the controller state untouched.
    `PPID_ASSERT_NEXT(a_band_hold, i_clk, i_rst_n, commit && n_in_band, $stable(r_error_sum) && $stable(r_last_error), "state changed inside deadband")
    // An active tick records its error as the last error.
    `PPID_ASSERT_NEXT(a_last_err, i_clk, i_rst_n, commit && !n_in_band, r_last_error == $past(n_e), "last error not updated")

endmodule

>>> sv/ppid_div1000.sv
// Two-part floor division by 1000: registered reciprocal product, then one correction.
`timescale 1ns / 1ps
module ppid_div1000 import ppid_pkg::*; (
    input  logic               i_clk,
    input  logic               i_load,
    input  logic [DIV_X_W-1:0] i_x,
    output logic [DIV_Q_W-1:0] o_quot
);

    logic [DIV_P_W-1:0] prod;
    logic [DIV_X_W-1:0] r_x;
    logic [DIV_Q_W-1:0] r_q0;
    logic [DIV_Q_W-1:0] n_q0;
    logic [DIV_X_W-1:0] rem;

    // The truncated reciprocal makes the estimate exact or one short.
    always_comb begin
        prod = DIV_P_W'(i_x) * DIV_P_W'(DIV_RECIP);
        n_q0 = prod[DIV_SHIFT +: DIV_Q_W];
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_x  <= i_x;
            r_q0 <= n_q0;
        end
    end

    always_comb begin
        rem    = r_x - DIV_X_W'(r_q0) * DIVISOR;
        o_quot = r_q0 + DIV_Q_W'(rem >= DIVISOR);
    end

endmodule
